@@ rtl/ang_pkg.sv @@
package ang_pkg;

	localparam int WORD_W     = 32;
	localparam int SHIFT_W    = 5;
	localparam int THR_W      = 24;
	localparam int RATE_W     = 25;
	localparam int ENV_W      = 48;
	localparam int PCM_W      = 16;
	localparam int MAG_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;
	localparam int OUT_DATA_W = 48;

	// serial multiply-accumulate
	localparam int X_W    = 48;
	localparam int DIG_W  = 5;
	localparam int N_DIG  = RATE_W / DIG_W;
	localparam int CNT_W  = $clog2(N_DIG);
	localparam int ACC_W  = X_W + DIG_W + 2;
	localparam int RES_W  = ACC_W + 1;

	localparam logic [RATE_W-1:0] ONE_Q24 = RATE_W'(1) << 24;

	localparam logic [CFG_IDX_W-1:0] REG_OPEN_THR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_THR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENV_RATE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATK_RATE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REL_RATE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT     = 3'd6;

	typedef struct packed {
		logic              start;
		logic [X_W-1:0]    x0;
		logic [RATE_W-1:0] y0;
		logic [X_W-1:0]    x1;
		logic [RATE_W-1:0] y1;
	} mac_req_t;

	typedef struct packed {
		logic             done;
		logic [RES_W-1:0] value;
	} mac_rsp_t;

endpackage

@@ rtl/ang_mag.sv @@
module ang_mag (
	input  logic [ang_pkg::WORD_W-1:0]  word,
	input  logic [ang_pkg::SHIFT_W-1:0] shift,
	output logic                        neg,
	output logic [ang_pkg::MAG_W-1:0]   mag
);

	logic [ang_pkg::WORD_W-1:0] src;
	logic [ang_pkg::WORD_W-1:0] shifted;

	assign neg     = word[ang_pkg::WORD_W-1];
	assign src     = neg ? ~word : word;
	assign shifted = src >> shift;
	assign mag     = neg ? shifted + ang_pkg::MAG_W'(1) : shifted;

endmodule

@@ rtl/ang_mac.sv @@
module ang_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  ang_pkg::mac_req_t req,
	output ang_pkg::mac_rsp_t rsp
);

	logic [ang_pkg::X_W-1:0]    x0_q;
	logic [ang_pkg::X_W-1:0]    x1_q;
	logic [ang_pkg::RATE_W-1:0] y0_q;
	logic [ang_pkg::RATE_W-1:0] y1_q;
	logic [ang_pkg::ACC_W-1:0]  acc_q;
	logic [ang_pkg::RATE_W-1:0] low_q;
	logic [ang_pkg::CNT_W-1:0]  cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [ang_pkg::ACC_W-1:0] pp0;
	logic [ang_pkg::ACC_W-1:0] pp1;
	logic [ang_pkg::ACC_W-1:0] sum;

	assign pp0 = ang_pkg::ACC_W'(x0_q) * ang_pkg::ACC_W'(y0_q[ang_pkg::DIG_W-1:0]);
	assign pp1 = ang_pkg::ACC_W'(x1_q) * ang_pkg::ACC_W'(y1_q[ang_pkg::DIG_W-1:0]);
	assign sum = acc_q + pp0 + pp1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				x0_q   <= req.x0;
				x1_q   <= req.x1;
				y0_q   <= req.y0;
				y1_q   <= req.y1;
				acc_q  <= '0;
				low_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				low_q <= {sum[ang_pkg::DIG_W-1:0], low_q[ang_pkg::RATE_W-1:ang_pkg::DIG_W]};
				acc_q <= sum >> ang_pkg::DIG_W;
				y0_q  <= y0_q >> ang_pkg::DIG_W;
				y1_q  <= y1_q >> ang_pkg::DIG_W;
				cnt_q <= cnt_q + ang_pkg::CNT_W'(1);
				if (cnt_q == ang_pkg::CNT_W'(ang_pkg::N_DIG - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// product shifted right by 24
	assign rsp.done  = done_q;
	assign rsp.value = {acc_q, low_q[ang_pkg::RATE_W-1]};

endmodule

@@ rtl/audio_noise_gate.sv @@
// Noise gate for left-channel I2S words. Each accepted word is shifted right
// arithmetically, drives a Q24.24 envelope follower with open/close hysteresis,
// and is scaled by a Q1.24 gain that slews toward its target at the attack or
// release rate; the result is the saturated 16-bit sample and the gain used.
// From acceptance to a result in the output register, each item makes three
// passes through one shared 5-bit-digit serial multiply-accumulate unit
// (envelope, gain, output scaling), each pass with the steps request, operand
// load, five digits and capture, and then an output step that waits while the
// output is stalled. A new item is taken only after the previous one left the
// unit; the output register holds a result while the next item is accepted.
module audio_noise_gate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ang_pkg::WORD_W-1:0]        s_tdata,  // i2s_word
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ang_pkg::OUT_DATA_W-1:0]    m_tdata,  // pcm_sample, applied_gain
	input  logic                              cfg_we,
	input  logic [ang_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ang_pkg::CFG_DATA_W-1:0]    cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ENV,
		S_ENV_W,
		S_GAIN,
		S_GAIN_W,
		S_PCM,
		S_PCM_W,
		S_OUT
	} state_t;

	state_t state_q;

	logic [ang_pkg::THR_W-1:0]   open_thr_q;
	logic [ang_pkg::THR_W-1:0]   close_thr_q;
	logic [ang_pkg::RATE_W-1:0]  env_rate_q;
	logic [ang_pkg::RATE_W-1:0]  atk_rate_q;
	logic [ang_pkg::RATE_W-1:0]  rel_rate_q;
	logic [ang_pkg::RATE_W-1:0]  floor_q;
	logic [ang_pkg::SHIFT_W-1:0] shift_q;

	logic [ang_pkg::ENV_W-1:0]  envelope_q;
	logic [ang_pkg::RATE_W-1:0] gain_q;
	logic [ang_pkg::MAG_W-1:0]  mag_q;
	logic                       neg_q;
	logic                       m_tvalid_q;
	logic [ang_pkg::PCM_W-1:0]  pcm_q;
	logic [ang_pkg::RATE_W-1:0] gain_out_q;

	ang_pkg::mac_req_t req_q;
	ang_pkg::mac_rsp_t rsp;

	logic                       in_neg;
	logic [ang_pkg::MAG_W-1:0]  in_mag;
	logic [ang_pkg::THR_W-1:0]  env_in;
	logic [ang_pkg::RATE_W-1:0] env_r;
	logic [ang_pkg::RATE_W-1:0] floor_cap;
	logic [ang_pkg::RATE_W-1:0] atk_cap;
	logic [ang_pkg::RATE_W-1:0] rel_cap;
	logic [ang_pkg::RATE_W-1:0] target;
	logic [ang_pkg::RATE_W-1:0] gain_r;
	logic [ang_pkg::RATE_W-1:0] pcm_src;
	logic [ang_pkg::PCM_W-1:0]  pcm;

	function automatic logic [ang_pkg::RATE_W-1:0] cap_one(input logic [ang_pkg::RATE_W-1:0] v);
		return (v > ang_pkg::ONE_Q24) ? ang_pkg::ONE_Q24 : v;
	endfunction

	ang_mag u_mag (
		.word  (s_tdata),
		.shift (shift_q),
		.neg   (in_neg),
		.mag   (in_mag)
	);

	ang_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_thr_q  <= ang_pkg::THR_W'(1600);
			close_thr_q <= ang_pkg::THR_W'(1200);
			env_rate_q  <= ang_pkg::RATE_W'(167772);
			atk_rate_q  <= ang_pkg::RATE_W'(34917);
			rel_rate_q  <= ang_pkg::RATE_W'(2912);
			floor_q     <= '0;
			shift_q     <= ang_pkg::SHIFT_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				ang_pkg::REG_OPEN_THR:  open_thr_q  <= cfg_data[ang_pkg::THR_W-1:0];
				ang_pkg::REG_CLOSE_THR: close_thr_q <= cfg_data[ang_pkg::THR_W-1:0];
				ang_pkg::REG_ENV_RATE:  env_rate_q  <= cfg_data;
				ang_pkg::REG_ATK_RATE:  atk_rate_q  <= cfg_data;
				ang_pkg::REG_REL_RATE:  rel_rate_q  <= cfg_data;
				ang_pkg::REG_FLOOR:     floor_q     <= cfg_data;
				ang_pkg::REG_SHIFT:     shift_q     <= cfg_data[ang_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	assign env_in    = (|mag_q[ang_pkg::MAG_W-1:ang_pkg::THR_W]) ? '1 :
	                   mag_q[ang_pkg::THR_W-1:0];
	assign env_r     = cap_one(env_rate_q);
	assign floor_cap = cap_one(floor_q);
	assign atk_cap   = cap_one(atk_rate_q);
	assign rel_cap   = cap_one(rel_rate_q);

	// hysteresis: open test first
	always_comb begin
		if (envelope_q[ang_pkg::ENV_W-1:24] >= open_thr_q) begin
			target = ang_pkg::ONE_Q24;
		end else if (envelope_q[ang_pkg::ENV_W-1:24] < close_thr_q) begin
			target = floor_cap;
		end else begin
			target = gain_q;
		end
	end

	assign gain_r  = (target > gain_q) ? atk_cap : rel_cap;
	assign pcm_src = '0;

	always_comb begin
		if (neg_q) begin
			if (rsp.value > ang_pkg::RES_W'(32768)) begin
				pcm = 16'h8000;
			end else begin
				pcm = 16'h0000 - rsp.value[ang_pkg::PCM_W-1:0];
			end
		end else begin
			if (rsp.value > ang_pkg::RES_W'(32767)) begin
				pcm = 16'h7fff;
			end else begin
				pcm = rsp.value[ang_pkg::PCM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q.start <= 1'b0;
			m_tvalid_q  <= 1'b0;
			envelope_q  <= '0;
			gain_q      <= '0;
		end else begin
			req_q.start <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						mag_q   <= in_mag;
						neg_q   <= in_neg;
						state_q <= S_ENV;
					end
				end
				S_ENV: begin
					req_q.start <= 1'b1;
					req_q.x0    <= envelope_q;
					req_q.y0    <= ang_pkg::ONE_Q24 - env_r;
					req_q.x1    <= {env_in, 24'h000000};
					req_q.y1    <= env_r;
					state_q     <= S_ENV_W;
				end
				S_ENV_W: begin
					if (rsp.done) begin
						envelope_q <= rsp.value[ang_pkg::ENV_W-1:0];
						state_q    <= S_GAIN;
					end
				end
				S_GAIN: begin
					req_q.start <= 1'b1;
					req_q.x0    <= ang_pkg::X_W'(gain_q);
					req_q.y0    <= ang_pkg::ONE_Q24 - gain_r;
					req_q.x1    <= ang_pkg::X_W'(target);
					req_q.y1    <= gain_r;
					state_q     <= S_GAIN_W;
				end
				S_GAIN_W: begin
					if (rsp.done) begin
						gain_q  <= rsp.value[ang_pkg::RATE_W-1:0];
						state_q <= S_PCM;
					end
				end
				S_PCM: begin
					req_q.start <= 1'b1;
					req_q.x0    <= ang_pkg::X_W'(mag_q);
					req_q.y0    <= gain_q;
					req_q.x1    <= '0;
					req_q.y1    <= pcm_src;
					state_q     <= S_PCM_W;
				end
				S_PCM_W: begin
					if (rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						pcm_q      <= pcm;
						gain_out_q <= gain_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0000000, gain_out_q, pcm_q};

endmodule
